[design/assert_macros.svh]
// Assertion helpers shared by the RTL. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check that a condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Check that a trigger is followed by a consequence on the next clock edge
`define ASSERT_NEXT(lbl, clk, rst, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`define ASSERT_NEXT(lbl, clk, rst, trig, cons, msg)
`endif

`endif

[design/tbp_pkg.sv]
package tbp_pkg;

  // Global history width and the width of the history length register
  localparam int HIST_W = 11;
  localparam int HLEN_W = 4;
  localparam logic [HLEN_W-1:0] HLEN_RESET = 4'd11;

  // Two-bit saturating counters
  localparam int CTR_W = 2;
  localparam logic [CTR_W-1:0] CTR_MIN = 2'd0;
  localparam logic [CTR_W-1:0] CTR_MAX = 2'd3;
  localparam logic [CTR_W-1:0] DIR_RESET = 2'd3;  // strongly taken
  localparam logic [CTR_W-1:0] CHO_RESET = 2'd0;  // strongly prefer gshare

  // Stream payload widths
  localparam int ADDR_W = 32;
  localparam int CNT_W = 32;
  localparam int IN_DATA_W = 40;
  localparam int OUT_DATA_W = 72;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_HISTORY_LENGTH = 1'b0;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } tbp_state_t;

  typedef struct packed {
    logic accept;
    logic commit;
    logic clear_step;
  } tbp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } tbp_status_t;

  // Saturating two-bit counter step
  function automatic logic [CTR_W-1:0] train2(input logic [CTR_W-1:0] c, input logic up);
    logic [CTR_W-1:0] r;
    if (up) begin
      r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
    end else begin
      r = (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
    end
    return r;
  endfunction

  // Mask of the kept history bits; length clamped to 1..HIST_W
  function automatic logic [HIST_W-1:0] hist_mask(input logic [HLEN_W-1:0] len);
    logic [HLEN_W-1:0] l;
    logic [HIST_W-1:0] m;
    l = len;
    if (l == '0) begin
      l = 4'd1;
    end
    if (l > HLEN_W'(HIST_W)) begin
      l = HLEN_W'(HIST_W);
    end
    for (int i = 0; i < HIST_W; i++) begin
      m[i] = (i < int'(l));
    end
    return m;
  endfunction

endpackage

[design/tbp_ram.sv]
module tbp_ram
  #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2048
  ) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
  );

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/tbp_ctrl.sv]
module tbp_ctrl
  import tbp_pkg::*;
  (
    input  logic        clk,
    input  logic        rst,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  tbp_status_t status,
    output tbp_cmd_t    cmd
  );

  tbp_state_t state;
  tbp_state_t state_next;

  // State register; reset starts the table clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next     = state;
    s_tready       = 1'b0;
    cmd.accept     = 1'b0;
    cmd.commit     = 1'b0;
    cmd.clear_step = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        // Wait for the output register to free up before updating
        cmd.commit = status.out_free;
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

[design/tbp_datapath.sv]
module tbp_datapath
  import tbp_pkg::*;
  #(
    parameter int INDEX_BITS = 11
  ) (
    input  logic                  clk,
    input  logic                  rst,
    input  tbp_cmd_t              cmd,
    output tbp_status_t           status,
    input  logic [HLEN_W-1:0]     history_length,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
  );

  localparam int DEPTH = 1 << INDEX_BITS;
  localparam int XW = (INDEX_BITS > HIST_W) ? INDEX_BITS : HIST_W;

  logic [INDEX_BITS-1:0] clr_addr;
  logic [HIST_W-1:0]     hist;
  logic [HIST_W-1:0]     hmask;
  logic [XW-1:0]         hist_x;
  logic [INDEX_BITS-1:0] bidx_in;
  logic [INDEX_BITS-1:0] gidx_in;
  logic [INDEX_BITS-1:0] bidx;
  logic [INDEX_BITS-1:0] gidx;
  logic                  taken;
  logic [CNT_W-1:0]      branch_count;
  logic [CNT_W-1:0]      correct_count;
  logic [CNT_W-1:0]      branch_count_next;
  logic [CNT_W-1:0]      correct_count_next;

  logic [CTR_W-1:0] bim_rd, gsh_rd, cho_rd;
  logic [CTR_W-1:0] bim_wd, gsh_wd, cho_wd;
  logic [INDEX_BITS-1:0] b_waddr, g_waddr;
  logic ram_we;
  logic bpred, gpred, use_bi, pred, ok;

  // Index computation for an incoming branch
  always_comb begin
    hmask   = hist_mask(history_length);
    hist_x  = XW'(hist & hmask);
    bidx_in = s_tdata[INDEX_BITS-1:0];
    gidx_in = bidx_in ^ hist_x[INDEX_BITS-1:0];
  end

  // Capture the item's indices and outcome on transfer
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      bidx  <= bidx_in;
      gidx  <= gidx_in;
      taken <= s_tdata[ADDR_W];
    end
  end

  // Clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Predictions and counter updates from the registered table reads
  always_comb begin
    bpred  = bim_rd[CTR_W-1];
    gpred  = gsh_rd[CTR_W-1];
    use_bi = cho_rd[CTR_W-1];
    pred   = use_bi ? bpred : gpred;
    ok     = (pred == taken);
    ram_we = cmd.commit | cmd.clear_step;
    if (cmd.clear_step) begin
      b_waddr = clr_addr;
      g_waddr = clr_addr;
      bim_wd  = DIR_RESET;
      gsh_wd  = DIR_RESET;
      cho_wd  = CHO_RESET;
    end else begin
      b_waddr = bidx;
      g_waddr = gidx;
      bim_wd  = train2(bim_rd, taken);
      gsh_wd  = train2(gsh_rd, taken);
      cho_wd  = (bpred != gpred) ? train2(cho_rd, bpred == taken) : cho_rd;
    end
    branch_count_next  = (branch_count != '1) ? branch_count + 1'b1 : branch_count;
    correct_count_next = (ok && correct_count != '1) ? correct_count + 1'b1
                                                      : correct_count;
  end

  tbp_ram #(.WIDTH(CTR_W), .DEPTH(DEPTH)) u_bim_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (b_waddr),
    .wdata (bim_wd),
    .re    (cmd.accept),
    .raddr (bidx_in),
    .rdata (bim_rd)
  );

  tbp_ram #(.WIDTH(CTR_W), .DEPTH(DEPTH)) u_gsh_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (g_waddr),
    .wdata (gsh_wd),
    .re    (cmd.accept),
    .raddr (gidx_in),
    .rdata (gsh_rd)
  );

  tbp_ram #(.WIDTH(CTR_W), .DEPTH(DEPTH)) u_cho_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (b_waddr),
    .wdata (cho_wd),
    .re    (cmd.accept),
    .raddr (bidx_in),
    .rdata (cho_rd)
  );

  // History and running counts advance on commit
  always_ff @(posedge clk) begin
    if (rst) begin
      hist          <= '0;
      branch_count  <= '0;
      correct_count <= '0;
    end else if (cmd.commit) begin
      hist          <= ((hist << 1) & hmask) ^ HIST_W'(taken);
      branch_count  <= branch_count_next;
      correct_count <= correct_count_next;
    end
  end

  // Output register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= {3'b000, correct_count_next, branch_count_next,
                  ok, use_bi, gpred, bpred, pred};
    end
  end

  always_comb begin
    status.clear_last = &clr_addr;
    status.out_free   = ~m_tvalid | m_tready;
  end

endmodule

[design/tournament_branch_predictor.sv]
// Tournament branch predictor (gshare plus bimodal with a per-address chooser).
// Each input transfer is one resolved conditional branch; each output transfer
// reports both component predictions, the chosen one, whether it was right and
// saturating branch and correct counts. Accepting an item starts the synchronous
// reads of the three counter RAMs; once the output register is free, the block
// forms the result and writes the updated counters back. Items are handled
// one at a time, and a finished result waits in an output register so the
// next item can be accepted meanwhile. After reset the block clears its
// 2**INDEX_BITS table entries with s_tready low, taking configuration writes
// meanwhile. Register 0 (byte address 0) is history_length, clamped to 1..11.
`include "assert_macros.svh"

module tournament_branch_predictor
  import tbp_pkg::*;
  #(
    parameter int INDEX_BITS = 11
  ) (
    input  logic                  clk,
    input  logic                  rst,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [31:0] branch_address, [32] taken, [39:33] zero
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] prediction, [1] bimodal_prediction, [2] gshare_prediction,
    // [3] used_bimodal, [4] was_correct, [36:5] branch_count,
    // [68:37] correct_count, [71:69] zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready
  );

  tbp_cmd_t          cmd;
  tbp_status_t       status;
  logic [HLEN_W-1:0] history_length;
  logic              cfg_write;

  // Configuration register
  always_comb begin
    pready    = 1'b1;
    cfg_write = psel & penable & pwrite & pready;
    prdata    = (paddr[2] == REG_HISTORY_LENGTH) ? PDATA_W'(history_length) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      history_length <= HLEN_RESET;
    end else if (cfg_write && paddr[2] == REG_HISTORY_LENGTH) begin
      history_length <= pwdata[HLEN_W-1:0];
    end
  end

  tbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tbp_datapath #(.INDEX_BITS(INDEX_BITS)) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .history_length (history_length),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata)
  );

  // One branch in flight: no transfer right after one was taken
  `ASSERT_NEXT(a_one_in_flight, clk, rst, s_tvalid && s_tready, !s_tready, "second item accepted while busy")
  // A committed result shows up on the output
  `ASSERT_NEXT(a_commit_shows, clk, rst, cmd.commit, m_tvalid, "committed result not presented")
  // No input transfer while the tables are being cleared
  `ASSERT_ALWAYS(a_clear_blocks, clk, rst, !(cmd.clear_step && s_tready), "input ready during clearing pass")

endmodule
